// ===== hw/rtl/gcgc_pkg.sv =====
// ----------------------------------------------------------------------------
// gcgc_pkg
// Shared types and constants of the grid cell ground classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package gcgc_pkg;

    // Grid size defaults
    localparam int MAX_COLUMNS_DEF = 512;
    localparam int MAX_ROWS_DEF    = 512;

    // Full cell count
    localparam logic [15:0] COUNT_FULL = 16'hFFFF;

    // Item modes and result kinds
    localparam logic MODE_ADD   = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // Configuration register indexes
    localparam logic [2:0] CFG_COLUMNS = 3'd0;
    localparam logic [2:0] CFG_ROWS    = 3'd1;
    localparam logic [2:0] CFG_WIDTH   = 3'd2;
    localparam logic [2:0] CFG_DEPTH   = 3'd3;
    localparam logic [2:0] CFG_ILIM    = 3'd4;
    localparam logic [2:0] CFG_HLIM    = 3'd5;
    localparam logic [2:0] CFG_SPREAD  = 3'd6;

    // Configuration reset values
    localparam logic [9:0]  RST_COLUMNS = 10'd500;
    localparam logic [9:0]  RST_ROWS    = 10'd300;
    localparam logic [12:0] RST_WIDTH   = 13'd100;
    localparam logic [12:0] RST_DEPTH   = 13'd100;
    localparam logic [7:0]  RST_ILIM    = 8'd18;
    localparam logic [15:0] RST_HLIM    = 16'hFED4;
    localparam logic [31:0] RST_SPREAD  = 32'd100;

    typedef struct packed {
        logic [9:0]         columns;
        logic [9:0]         rows;
        logic [12:0]        width;
        logic [12:0]        depth;
        logic [7:0]         ilim;
        logic signed [15:0] hlim;
        logic [31:0]        spread;
    } t_cfg;

    // Job handed from the front to the back
    typedef struct packed {
        logic               kind;
        logic               hit;
        logic [9:0]         col;
        logic [9:0]         row;
        logic signed [15:0] z;
        logic [30:0]        zsq;
        logic [7:0]         intensity;
    } t_job;

endpackage

`default_nettype wire

// ===== hw/rtl/gcgc_front.sv =====
// ----------------------------------------------------------------------------
// gcgc_front
// Accepts items, locates points in the grid with two bit-serial dividers and
// checks queries against the grid, then pushes one job into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module gcgc_front #(
    parameter int MAX_COLUMNS = gcgc_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = gcgc_pkg::MAX_ROWS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic          i_mode,
    input  wire logic [15:0]   i_x_mm,
    input  wire logic [15:0]   i_y_mm,
    input  wire logic [15:0]   i_z_mm,
    input  wire logic [7:0]    i_intensity,
    input  wire logic [8:0]    i_query_column,
    input  wire logic [8:0]    i_query_row,
    input  wire gcgc_pkg::t_cfg i_cfg,
    input  wire logic          i_full,
    output logic               o_push,
    output gcgc_pkg::t_job     o_job
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_DIV  = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;
    localparam logic [4:0] LAST_STEP = 5'd16;

    logic [1:0]         r_state, n_state;
    logic               r_mode;
    logic               r_xneg, r_yneg;
    logic signed [15:0] r_z;
    logic [30:0]        r_zsq;
    logic [7:0]         r_int;
    logic [8:0]         r_qc, r_qr;
    logic [16:0]        r_xa, r_ya, r_xq, r_yq;
    logic [12:0]        r_xr, r_yr;
    logic [4:0]         r_step;

    logic [9:0]  w_ncol, w_nrow;
    logic [8:0]  w_hc, w_hr;
    logic [13:0] w_xt, w_yt;
    logic        w_xb, w_yb;
    logic        w_xhit, w_yhit, w_qin;
    logic [9:0]  w_xidx, w_yidx;
    logic        w_accept;

    // Clamp the grid size and halve it
    assign w_ncol = (int'(i_cfg.columns) > MAX_COLUMNS) ? 10'(MAX_COLUMNS) : i_cfg.columns;
    assign w_nrow = (int'(i_cfg.rows) > MAX_ROWS) ? 10'(MAX_ROWS) : i_cfg.rows;
    assign w_hc   = w_ncol[9:1];
    assign w_hr   = w_nrow[9:1];

    assign o_ready  = (r_state == F_IDLE);
    assign w_accept = i_valid && o_ready;

    // One restoring division step per axis
    assign w_xt = {r_xr, r_xa[16]};
    assign w_yt = {r_yr, r_ya[16]};
    assign w_xb = (w_xt >= {1'b0, i_cfg.width});
    assign w_yb = (w_yt >= {1'b0, i_cfg.depth});

    // Map quotient and remainder to a cell index along one axis
    function automatic logic [10:0] locate(input logic neg, input logic [16:0] uq,
                                           input logic [12:0] rem, input logic [12:0] size,
                                           input logic [8:0] half);
        logic       hit;
        logic [9:0] idx;
        hit = (size != 13'd0) && (half != 9'd0) && (rem != 13'd0) && (uq < {8'd0, half});
        idx = neg ? ({1'b0, half} - 10'd1 - {1'b0, uq[8:0]})
                  : ({1'b0, half} + {1'b0, uq[8:0]});
        return {hit, idx};
    endfunction

    assign {w_xhit, w_xidx} = locate(r_xneg, r_xq, r_xr, i_cfg.width, w_hc);
    assign {w_yhit, w_yidx} = locate(r_yneg, r_yq, r_yr, i_cfg.depth, w_hr);
    assign w_qin = ({1'b0, r_qc} < {w_hc, 1'b0}) && ({1'b0, r_qr} < {w_hr, 1'b0});

    // Build the job
    always_comb begin
        o_job.kind      = r_mode;
        o_job.hit       = (r_mode == gcgc_pkg::MODE_QUERY) ? w_qin : (w_xhit && w_yhit);
        o_job.col       = (r_mode == gcgc_pkg::MODE_QUERY) ? {1'b0, r_qc} : w_xidx;
        o_job.row       = (r_mode == gcgc_pkg::MODE_QUERY) ? {1'b0, r_qr} : w_yidx;
        o_job.z         = r_z;
        o_job.zsq       = r_zsq;
        o_job.intensity = r_int;
    end

    assign o_push = (r_state == F_PUSH) && !i_full;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (w_accept) n_state = (i_mode == gcgc_pkg::MODE_QUERY) ? F_PUSH : F_DIV;
            end
            F_DIV: begin
                if (r_step == LAST_STEP) n_state = F_PUSH;
            end
            F_PUSH: begin
                if (!i_full) n_state = F_IDLE;
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Latch the item and run the dividers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode <= i_mode;
            r_xneg <= i_x_mm[15];
            r_yneg <= i_y_mm[15];
            r_z    <= i_z_mm;
            r_zsq  <= 31'($signed(i_z_mm) * $signed(i_z_mm));
            r_int  <= i_intensity;
            r_qc   <= i_query_column;
            r_qr   <= i_query_row;
            r_xa   <= i_x_mm[15] ? (17'd0 - {i_x_mm[15], i_x_mm}) : {1'b0, i_x_mm};
            r_ya   <= i_y_mm[15] ? (17'd0 - {i_y_mm[15], i_y_mm}) : {1'b0, i_y_mm};
            r_xq   <= 17'd0;
            r_yq   <= 17'd0;
            r_xr   <= 13'd0;
            r_yr   <= 13'd0;
            r_step <= 5'd0;
        end else if (r_state == F_DIV) begin
            r_xa   <= {r_xa[15:0], 1'b0};
            r_ya   <= {r_ya[15:0], 1'b0};
            r_xq   <= {r_xq[15:0], w_xb};
            r_yq   <= {r_yq[15:0], w_yb};
            r_xr   <= w_xb ? 13'(w_xt - {1'b0, i_cfg.width}) : w_xt[12:0];
            r_yr   <= w_yb ? 13'(w_yt - {1'b0, i_cfg.depth}) : w_yt[12:0];
            r_step <= r_step + 5'd1;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/gcgc_queue.sv =====
// ----------------------------------------------------------------------------
// gcgc_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module gcgc_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire gcgc_pkg::t_job i_job,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_empty,
    output gcgc_pkg::t_job     o_job
);

    gcgc_pkg::t_job r_mem [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_mem[r_rp];

    // Store pushed jobs
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 2'd1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 2'd1;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/gcgc_back.sv =====
// ----------------------------------------------------------------------------
// gcgc_back
// Owns the cell memory: clears it after reset, adds points, reads and clears
// queried cells, works out the verdict and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gcgc_back #(
    parameter int MAX_COLUMNS = gcgc_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = gcgc_pkg::MAX_ROWS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire gcgc_pkg::t_cfg i_cfg,
    input  wire logic           i_empty,
    input  wire gcgc_pkg::t_job i_job,
    output logic                o_pop,
    output logic                o_valid,
    input  wire logic           i_ready,
    output logic                o_kind,
    output logic                o_accepted,
    output logic [8:0]          o_col,
    output logic [8:0]          o_row,
    output logic [15:0]         o_count,
    output logic                o_drivable
);

    localparam int CW    = $clog2(MAX_COLUMNS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int AW    = CW + RW;
    localparam int DEPTH = 1 << AW;

    localparam logic [2:0] B_CLEAR = 3'd0;
    localparam logic [2:0] B_IDLE  = 3'd1;
    localparam logic [2:0] B_CALC  = 3'd2;
    localparam logic [2:0] B_SUM   = 3'd3;
    localparam logic [2:0] B_CMP   = 3'd4;
    localparam logic [2:0] B_EMIT  = 3'd5;

    typedef struct packed {
        logic [15:0]        count;
        logic signed [32:0] hsum;
        logic [45:0]        sqsum;
        logic [23:0]        isum;
    } t_cell;

    t_cell          r_mem [DEPTH];
    t_cell          r_rd;
    logic [2:0]     r_state, n_state;
    logic [AW-1:0]  r_clr_addr, r_addr;
    logic           r_kind;
    logic signed [15:0] r_z;
    logic [30:0]    r_zsq;
    logic [7:0]     r_int;

    logic           r_res_acc, r_res_drv;
    logic [8:0]     r_res_col, r_res_row;
    logic [15:0]    r_res_cnt;
    logic           r_ok_i, r_ok_h;
    logic [38:0]    r_p0, r_p1;
    logic [31:0]    r_hh;
    logic [32:0]    r_hl;
    logic [33:0]    r_ll;
    logic [47:0]    r_spn;
    logic [63:0]    r_nq, r_ss;

    logic           r_out_valid, r_out_kind, r_out_acc, r_out_drv;
    logic [8:0]     r_out_col, r_out_row;
    logic [15:0]    r_out_cnt;

    logic           w_we, w_re, w_full_cell, w_slot;
    logic [AW-1:0]  w_waddr, w_raddr;
    t_cell          w_wdata, w_add;
    logic [32:0]    w_sabs;
    logic signed [32:0] w_hn;
    logic [63:0]    w_dev;

    assign o_pop       = (r_state == B_IDLE) && !i_empty;
    assign w_raddr     = {CW'(i_job.col), RW'(i_job.row)};
    assign w_re        = o_pop && i_job.hit;
    assign w_full_cell = (r_rd.count == gcgc_pkg::COUNT_FULL);
    assign w_slot      = !r_out_valid || i_ready;

    // Accumulate one point
    always_comb begin
        w_add.count = r_rd.count + 16'd1;
        w_add.hsum  = r_rd.hsum + 33'(r_z);
        w_add.sqsum = r_rd.sqsum + {15'd0, r_zsq};
        w_add.isum  = r_rd.isum + {16'd0, r_int};
    end

    // Select the memory write
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_addr;
        w_wdata = '0;
        if (r_state == B_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_clr_addr;
        end else if (r_state == B_CALC) begin
            if (r_kind == gcgc_pkg::MODE_QUERY) begin
                w_we = 1'b1;
            end else if (!w_full_cell) begin
                w_we    = 1'b1;
                w_wdata = w_add;
            end
        end
    end

    // Cell memory
    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        if (w_re) r_rd <= r_mem[w_raddr];
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_CLEAR: begin
                if (&r_clr_addr) n_state = B_IDLE;
            end
            B_IDLE: begin
                if (o_pop) n_state = i_job.hit ? B_CALC : B_EMIT;
            end
            B_CALC: begin
                n_state = (r_kind == gcgc_pkg::MODE_QUERY) ? B_SUM : B_EMIT;
            end
            B_SUM:  n_state = B_CMP;
            B_CMP:  n_state = B_EMIT;
            B_EMIT: begin
                if (w_slot) n_state = B_IDLE;
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= B_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == B_CLEAR) r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // Verdict terms
    assign w_sabs = r_rd.hsum[32] ? 33'(-r_rd.hsum) : 33'(r_rd.hsum);
    assign w_hn   = i_cfg.hlim * $signed({1'b0, r_rd.count});
    assign w_dev  = (r_nq >= r_ss) ? (r_nq - r_ss) : 64'd0;

    // Work through the job
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            B_IDLE: begin
                if (o_pop) begin
                    r_kind    <= i_job.kind;
                    r_addr    <= w_raddr;
                    r_z       <= i_job.z;
                    r_zsq     <= i_job.zsq;
                    r_int     <= i_job.intensity;
                    r_res_acc <= 1'b0;
                    r_res_cnt <= 16'd0;
                    r_res_drv <= 1'b0;
                    if (i_job.kind == gcgc_pkg::MODE_QUERY || i_job.hit) begin
                        r_res_col <= i_job.col[8:0];
                        r_res_row <= i_job.row[8:0];
                    end else begin
                        r_res_col <= 9'd0;
                        r_res_row <= 9'd0;
                    end
                end
            end
            B_CALC: begin
                if (r_kind == gcgc_pkg::MODE_QUERY) begin
                    r_res_cnt <= r_rd.count;
                end else if (w_full_cell) begin
                    r_res_col <= 9'd0;
                    r_res_row <= 9'd0;
                end else begin
                    r_res_acc <= 1'b1;
                    r_res_cnt <= w_add.count;
                end
                r_p0   <= {23'd0, r_rd.count} * {16'd0, r_rd.sqsum[22:0]};
                r_p1   <= {23'd0, r_rd.count} * {16'd0, r_rd.sqsum[45:23]};
                r_hh   <= {16'd0, w_sabs[32:17]} * {16'd0, w_sabs[32:17]};
                r_hl   <= {17'd0, w_sabs[32:17]} * {16'd0, w_sabs[16:0]};
                r_ll   <= {17'd0, w_sabs[16:0]} * {17'd0, w_sabs[16:0]};
                r_spn  <= {16'd0, i_cfg.spread} * {32'd0, r_rd.count};
                r_ok_i <= r_rd.isum < ({16'd0, i_cfg.ilim} * {8'd0, r_rd.count});
                r_ok_h <= r_rd.hsum < w_hn;
            end
            B_SUM: begin
                r_nq <= {2'd0, r_p1, 23'd0} + {25'd0, r_p0};
                r_ss <= {r_hh[29:0], 34'd0} + {13'd0, r_hl, 18'd0} + {30'd0, r_ll};
            end
            B_CMP: begin
                r_res_drv <= (r_res_cnt != 16'd0) && r_ok_i && r_ok_h
                             && (w_dev < {16'd0, r_spn});
            end
            default: begin
            end
        endcase
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == B_EMIT && w_slot) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == B_EMIT && w_slot) begin
            r_out_kind <= r_kind;
            r_out_acc  <= r_res_acc;
            r_out_col  <= r_res_col;
            r_out_row  <= r_res_row;
            r_out_cnt  <= r_res_cnt;
            r_out_drv  <= r_res_drv;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_kind     = r_out_kind;
    assign o_accepted = r_out_acc;
    assign o_col      = r_out_col;
    assign o_row      = r_out_row;
    assign o_count    = r_out_cnt;
    assign o_drivable = r_out_drv;

endmodule

`default_nettype wire

// ===== hw/rtl/grid_cell_ground_classifier.sv =====
// ----------------------------------------------------------------------------
// grid_cell_ground_classifier
// Bins lidar points into grid cells and reports per-cell drivable verdicts.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries items: tuser is the mode (add point or query cell), tdata
//   the point and query fields. m_axis returns exactly one result per item,
//   tuser the result kind. The cfg channel writes the seven registers and is
//   always ready; write it only while the block is idle.
//   Flow: an added point passes through the front in an accept state, 17
//   steps of the two bit-serial coordinate dividers and a push state; a
//   query skips the dividers. The back takes a dropped item from idle to
//   emit, an add through a calc state and a query through calc, sum and
//   compare states, with one write port and one registered read port.
//   The front and back overlap through a two-entry queue, so the front
//   divider sets the rate for point streams and the back for query streams.
//   Reset: registers take their defaults, then the back clears all
//   MAX_COLUMNS_POW2 * MAX_ROWS_POW2 cells of the memory, one cell per cycle
//   (262144 at the default size); items are accepted and queued meanwhile.
//   When m_axis stalls the result holds, the queue fills, then s_axis stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_cell_ground_classifier #(
    parameter int MAX_COLUMNS = gcgc_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = gcgc_pkg::MAX_ROWS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // mode
    input  wire logic [0:0]  s_axis_tuser,
    // x_mm, y_mm, z_mm, point_intensity, query_column, query_row, pad
    input  wire logic [79:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // kind
    output logic [0:0]       m_axis_tuser,
    // accepted, cell_column, cell_row, point_count, drivable, pad
    output logic [39:0]      m_axis_tdata,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    gcgc_pkg::t_cfg r_cfg;
    gcgc_pkg::t_job w_fjob, w_qjob;
    logic           w_push, w_full, w_pop, w_empty;
    logic           w_acc, w_drv;
    logic [8:0]     w_col, w_row;
    logic [15:0]    w_cnt;

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.columns <= gcgc_pkg::RST_COLUMNS;
            r_cfg.rows    <= gcgc_pkg::RST_ROWS;
            r_cfg.width   <= gcgc_pkg::RST_WIDTH;
            r_cfg.depth   <= gcgc_pkg::RST_DEPTH;
            r_cfg.ilim    <= gcgc_pkg::RST_ILIM;
            r_cfg.hlim    <= gcgc_pkg::RST_HLIM;
            r_cfg.spread  <= gcgc_pkg::RST_SPREAD;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                gcgc_pkg::CFG_COLUMNS: r_cfg.columns <= i_cfg_data[9:0];
                gcgc_pkg::CFG_ROWS:    r_cfg.rows    <= i_cfg_data[9:0];
                gcgc_pkg::CFG_WIDTH:   r_cfg.width   <= i_cfg_data[12:0];
                gcgc_pkg::CFG_DEPTH:   r_cfg.depth   <= i_cfg_data[12:0];
                gcgc_pkg::CFG_ILIM:    r_cfg.ilim    <= i_cfg_data[7:0];
                gcgc_pkg::CFG_HLIM:    r_cfg.hlim    <= i_cfg_data[15:0];
                gcgc_pkg::CFG_SPREAD:  r_cfg.spread  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    gcgc_front #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_mode         (s_axis_tuser[0]),
        .i_x_mm         (s_axis_tdata[15:0]),
        .i_y_mm         (s_axis_tdata[31:16]),
        .i_z_mm         (s_axis_tdata[47:32]),
        .i_intensity    (s_axis_tdata[55:48]),
        .i_query_column (s_axis_tdata[64:56]),
        .i_query_row    (s_axis_tdata[73:65]),
        .i_cfg          (r_cfg),
        .i_full         (w_full),
        .o_push         (w_push),
        .o_job          (w_fjob)
    );

    gcgc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_fjob),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_job   (w_qjob)
    );

    gcgc_back #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_empty    (w_empty),
        .i_job      (w_qjob),
        .o_pop      (w_pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_kind     (m_axis_tuser[0]),
        .o_accepted (w_acc),
        .o_col      (w_col),
        .o_row      (w_row),
        .o_count    (w_cnt),
        .o_drivable (w_drv)
    );

    assign m_axis_tdata = {4'd0, w_drv, w_cnt, w_row, w_col, w_acc};

endmodule

`default_nettype wire

// ===== dv/grid_cell_ground_classifier_tb.sv =====
// ----------------------------------------------------------------------------
// grid_cell_ground_classifier_tb
// Streams points and cell queries through the classifier under random idling
// and checks every result item against a cycle-free model of the cell grid.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_cell_ground_classifier_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         GRID_ROWS   = gcgc_pkg::MAX_ROWS_DEF;
    localparam int         GRID_COLS   = gcgc_pkg::MAX_COLUMNS_DEF;
    localparam int         CYCLE_LIMIT = 3000000;
    localparam int         DRAIN_WAIT  = 60;
    localparam int         HOLD_CYCLES = 600;
    localparam logic [2:0] CFG_UNUSED  = 3'd7;

    typedef struct {
        logic               mode;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic [7:0]         inten;
        logic [8:0]         qcol;
        logic [8:0]         qrow;
    } t_point_item;

    typedef struct {
        logic        kind;
        logic        accepted;
        logic [8:0]  col;
        logic [8:0]  row;
        logic [15:0] count;
        logic        drivable;
    } t_cell_report;

    typedef struct {
        int unsigned       cnt;
        longint            hsum;
        longint unsigned   qsum;
        int unsigned       isum;
    } t_cell_acc;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [0:0]  s_axis_tuser = '0;
    logic [79:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [0:0]  m_axis_tuser;
    logic [39:0] m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    grid_cell_ground_classifier DUT (.*);

    // Model configuration
    int unsigned     m_cols, m_rows, m_width, m_depth, m_ilim;
    int              m_hlim;
    longint unsigned m_spread;
    t_cell_acc       grid_cells [int];

    t_point_item  pending_items [$];
    t_cell_report expected_reports [$];
    int           fail_count = 0;
    int           report_count = 0;
    int           verdict_count = 0;
    int           drivable_count = 0;
    longint       cycle_count = 0;
    logic         burst_mode = 1'b0;
    logic         hold_rx = 1'b0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        fail_count++;
        $display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, report_count);
    endtask

    // Append to the item and report queues
    task automatic enqueue_item(input t_point_item it);
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic enqueue_report(input t_cell_report rep);
        expected_reports.insert(expected_reports.size(), rep);
    endtask

    function automatic int half_of(int unsigned in_use, int unsigned max);
        return ((in_use > max) ? max : in_use) / 2;
    endfunction

    // Axis cell index, or -1 when on a border, outside or size zero
    function automatic int axis_cell(int coord, int unsigned size, int half);
        int s, q, r;
        if (size == 0 || half == 0) return -1;
        s = size;
        q = coord / s;
        r = coord % s;
        if (r == 0) return -1;
        if (coord < 0) q -= 1;
        if (q < -half || q >= half) return -1;
        return q + half;
    endfunction

    // Apply one item to the grid and return the report it produces
    function automatic t_cell_report classify_item(t_point_item it);
        t_cell_report    rep;
        t_cell_acc       acc;
        int              hc, hr, c, r, k;
        longint unsigned n, sabs, nq, ss, dev;
        logic            ok_i, ok_h, ok_s;
        hc = half_of(m_cols, GRID_COLS);
        hr = half_of(m_rows, GRID_ROWS);
        rep = '{default: '0};
        acc = '{default: 0};
        if (it.mode == gcgc_pkg::MODE_ADD) begin
            rep.kind = gcgc_pkg::MODE_ADD;
            c = axis_cell(int'(it.x), m_width, hc);
            r = axis_cell(int'(it.y), m_depth, hr);
            if (c >= 0 && r >= 0) begin
                k = c * GRID_ROWS + r;
                if (grid_cells.exists(k)) acc = grid_cells[k];
                if (acc.cnt < gcgc_pkg::COUNT_FULL) begin
                    acc.cnt++;
                    acc.hsum += it.z;
                    acc.qsum += longint'(it.z) * longint'(it.z);
                    acc.isum += it.inten;
                    grid_cells[k] = acc;
                    rep.accepted = 1'b1;
                    rep.col = c[8:0];
                    rep.row = r[8:0];
                    rep.count = acc.cnt[15:0];
                end
            end
        end else begin
            rep.kind = gcgc_pkg::MODE_QUERY;
            rep.col = it.qcol;
            rep.row = it.qrow;
            if (int'(it.qcol) < 2 * hc && int'(it.qrow) < 2 * hr) begin
                k = it.qcol * GRID_ROWS + it.qrow;
                if (grid_cells.exists(k)) acc = grid_cells[k];
                if (acc.cnt != 0) begin
                    n = acc.cnt;
                    sabs = (acc.hsum < 0) ? -acc.hsum : acc.hsum;
                    nq = n * acc.qsum;
                    ss = sabs * sabs;
                    dev = (nq >= ss) ? nq - ss : 0;
                    ok_i = acc.isum < m_ilim * n;
                    ok_h = acc.hsum < longint'(m_hlim) * longint'(n);
                    ok_s = dev < m_spread * n;
                    rep.count = acc.cnt[15:0];
                    rep.drivable = ok_i && ok_h && ok_s;
                end
                grid_cells.delete(k);
            end
        end
        return rep;
    endfunction

    // Driver: offer queued items with a random gap before each
    int tx_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                enqueue_report(classify_item('{
                    mode: s_axis_tuser[0], x: s_axis_tdata[15:0], y: s_axis_tdata[31:16],
                    z: s_axis_tdata[47:32], inten: s_axis_tdata[55:48],
                    qcol: s_axis_tdata[64:56], qrow: s_axis_tdata[73:65]}));
            end
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (tx_gap > 0) begin
                    tx_gap <= tx_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    t_point_item it;
                    it = pending_items.pop_front();
                    s_axis_tuser <= it.mode;
                    s_axis_tdata <= {6'b0, it.qrow, it.qcol, it.inten, it.z, it.y, it.x};
                    s_axis_tvalid <= 1'b1;
                    tx_gap <= burst_mode ? 0 : $urandom_range(0, 16);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stall at random, compare each result with the oldest report
    int rx_wait = 0;
    always @(posedge i_clk) begin
        int           wait_next;
        t_cell_report exp_rep;
        wait_next = (rx_wait > 0) ? rx_wait - 1 : 0;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            report_count++;
            wait_next = burst_mode ? 0 : $urandom_range(0, 16);
            if (expected_reports.size() == 0) begin
                report_mismatch("unexpected result", m_axis_tdata[34:19], -1);
            end else begin
                exp_rep = expected_reports.pop_front();
                if (exp_rep.kind == gcgc_pkg::MODE_QUERY) verdict_count++;
                if (exp_rep.drivable) drivable_count++;
                if (m_axis_tuser[0] != exp_rep.kind)
                    report_mismatch("kind", m_axis_tuser[0], exp_rep.kind);
                if (m_axis_tdata[0] != exp_rep.accepted)
                    report_mismatch("accepted", m_axis_tdata[0], exp_rep.accepted);
                if (m_axis_tdata[9:1] != exp_rep.col)
                    report_mismatch("cell_column", m_axis_tdata[9:1], exp_rep.col);
                if (m_axis_tdata[18:10] != exp_rep.row)
                    report_mismatch("cell_row", m_axis_tdata[18:10], exp_rep.row);
                if (m_axis_tdata[34:19] != exp_rep.count)
                    report_mismatch("point_count", m_axis_tdata[34:19], exp_rep.count);
                if (m_axis_tdata[35] != exp_rep.drivable)
                    report_mismatch("drivable", m_axis_tdata[35], exp_rep.drivable);
            end
        end
        rx_wait <= wait_next;
        m_axis_tready <= i_rst_n && !hold_rx && wait_next == 0;
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            gcgc_pkg::CFG_COLUMNS: m_cols = val[9:0];
            gcgc_pkg::CFG_ROWS:    m_rows = val[9:0];
            gcgc_pkg::CFG_WIDTH:   m_width = val[12:0];
            gcgc_pkg::CFG_DEPTH:   m_depth = val[12:0];
            gcgc_pkg::CFG_ILIM:    m_ilim = val[7:0];
            gcgc_pkg::CFG_HLIM:    m_hlim = $signed(val[15:0]);
            gcgc_pkg::CFG_SPREAD:  m_spread = val;
            default: ;
        endcase
    endtask

    task automatic set_grid(input int cols, input int rows, input int w, input int d,
                            input int ilim, input int hlim, input logic [31:0] spread);
        write_reg(gcgc_pkg::CFG_COLUMNS, cols);
        write_reg(gcgc_pkg::CFG_ROWS, rows);
        write_reg(gcgc_pkg::CFG_WIDTH, w);
        write_reg(gcgc_pkg::CFG_DEPTH, d);
        write_reg(gcgc_pkg::CFG_ILIM, ilim);
        write_reg(gcgc_pkg::CFG_HLIM, hlim);
        write_reg(gcgc_pkg::CFG_SPREAD, spread);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_idle();
        while (pending_items.size() > 0 || s_axis_tvalid || expected_reports.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic push_point(input int x, input int y, input int z, input int inten);
        enqueue_item('{gcgc_pkg::MODE_ADD, x[15:0], y[15:0], z[15:0], inten[7:0],
                       9'($urandom), 9'($urandom)});
    endtask

    task automatic push_query(input int qc, input int qr);
        enqueue_item('{gcgc_pkg::MODE_QUERY, 16'($urandom), 16'($urandom), 16'($urandom),
                       8'($urandom), qc[8:0], qr[8:0]});
    endtask

    // Random stream: mostly points inside the grid, queries on cells within the grid, some noise
    task automatic random_stream(input int count);
        int hc, hr, sel, x, y, z;
        hc = half_of(m_cols, GRID_COLS);
        hr = half_of(m_rows, GRID_ROWS);
        repeat (count) begin
            sel = $urandom_range(0, 99);
            if (sel < 10) begin
                enqueue_item('{$urandom_range(0, 1), 16'($urandom), 16'($urandom),
                    16'($urandom), 8'($urandom), 9'($urandom), 9'($urandom)});
            end else if (sel < 35) begin
                if (hc > 0 && hr > 0)
                    push_query($urandom_range(0, 2 * hc - 1), $urandom_range(0, 2 * hr - 1));
                else
                    push_query($urandom_range(0, 511), $urandom_range(0, 511));
            end else begin
                x = (hc > 0) ? int'($urandom_range(0, 2 * hc * m_width - 1)) - hc * m_width
                             : int'($urandom_range(0, 65535)) - 32768;
                y = (hr > 0) ? int'($urandom_range(0, 2 * hr * m_depth - 1)) - hr * m_depth
                             : int'($urandom_range(0, 65535)) - 32768;
                x = (x > 32767) ? 32767 : (x < -32768) ? -32768 : x;
                y = (y > 32767) ? 32767 : (y < -32768) ? -32768 : y;
                z = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 65535)) - 32768
                                                : int'($urandom_range(0, 60)) - 330;
                push_point(x, y, z, $urandom_range(0, 40));
            end
        end
    endtask

    initial begin
        m_cols = gcgc_pkg::RST_COLUMNS;
        m_rows = gcgc_pkg::RST_ROWS;
        m_width = gcgc_pkg::RST_WIDTH;
        m_depth = gcgc_pkg::RST_DEPTH;
        m_ilim = gcgc_pkg::RST_ILIM;
        m_hlim = $signed(gcgc_pkg::RST_HLIM);
        m_spread = gcgc_pkg::RST_SPREAD;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: defaults, borders, outside, extremes, queries
        push_point(50, 50, -320, 5);
        push_point(60, 40, -310, 10);
        push_point(100, 50, 0, 0);
        push_point(50, -200, 0, 0);
        push_point(32767, 32767, 32767, 255);
        push_point(-32768, -32768, -32768, 0);
        push_point(-24999, -14999, -32768, 255);
        push_point(24999, 14999, 32767, 0);
        push_point(-1, -1, -1, 255);
        push_query(250, 150);
        push_query(250, 150);
        push_query(0, 0);
        push_query(499, 299);
        push_query(511, 511);
        push_query(500, 300);
        wait_idle();

        // Clamped grid, unit cells: every point sits on a border
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        set_grid(1023, 1023, 1, 1, 255, 32767, 32'hFFFF_FFFF);
        push_point(5, 7, 1, 1);
        push_query(511, 511);
        wait_idle();

        // No cells at all, then zero cell size
        set_grid(0, 1, 4096, 4096, 0, -32768, 0);
        push_point(5, 7, 1, 1);
        push_query(0, 0);
        wait_idle();
        set_grid(8, 8, 0, 0, 0, 0, 0);
        push_point(5, 7, 1, 1);
        wait_idle();

        // Two by two giant cells with loose limits
        set_grid(2, 2, 4096, 4096, 255, 32767, 32'hFFFF_FFFF);
        push_point(1, 1, 100, 3);
        push_point(4095, 4095, -100, 9);
        push_point(-4095, -1, 5, 255);
        push_point(4096, 5, 5, 5);
        push_query(1, 1);
        push_query(0, 0);
        push_query(2, 0);
        wait_idle();

        // Random phases, one with a long receiver hold
        for (int ph = 0; ph < 5; ph++) begin
            set_grid($urandom_range(2, 10), $urandom_range(2, 10), $urandom_range(1, 300),
                     $urandom_range(1, 300), $urandom_range(0, 40),
                     int'($urandom_range(0, 80)) - 340,
                     (ph == 4) ? 32'hFFFF_FFFF : $urandom_range(0, 20000));
            burst_mode <= (ph == 2);
            random_stream(220);
            if (ph == 1) begin
                // Hold the receiver in a process of its own while items keep coming
                fork
                    begin
                        hold_rx <= 1'b1;
                        repeat (HOLD_CYCLES) @(posedge i_clk);
                        hold_rx <= 1'b0;
                    end
                join_none
            end
            wait_idle();
        end

        $display("checked %0d results: %0d cell verdicts, %0d drivable, over ten grid setups",
                 report_count, verdict_count, drivable_count);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
